/* src/plip_rr_pkg.sv */
// ----------------------------------------------------------------------------
// PLIP receive ring package
// Codes, phase types and the reset constant used by the receive ring module.
// ----------------------------------------------------------------------------
package plip_rr_pkg;

	// Kind of an input beat.
	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_BYTE    = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	// Receive outcome reported with each result.
	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_ACCEPTED = 3'd1,
		ST_NO_ROOM  = 3'd2,
		ST_CSUM_ERR = 3'd3,
		ST_ABORTED  = 3'd4
	} rx_status_t;

	// Kind of a popped byte.
	typedef enum logic [1:0] {
		OK_NONE   = 2'd0,
		OK_LEN_LO = 2'd1,
		OK_LEN_HI = 2'd2,
		OK_DATA   = 2'd3
	} out_kind_t;

	// Receive frame phase.
	typedef enum logic [2:0] {
		RX_IDLE   = 3'd0,
		RX_LEN_LO = 3'd1,
		RX_LEN_HI = 3'd2,
		RX_DATA   = 3'd3,
		RX_SUM    = 3'd4
	} rx_phase_t;

	// Read-out phase of the oldest stored packet.
	typedef enum logic [1:0] {
		RD_START  = 2'd0,
		RD_LEN_HI = 2'd1,
		RD_DATA   = 2'd2
	} rd_phase_t;

	localparam logic [15:0] MAX_LEN_RESET = 16'd1500;

endpackage

/* src/plip_rr_ram.sv */
// ----------------------------------------------------------------------------
// PLIP receive ring byte store
// Single write port, single registered read port, read-before-write.
// ----------------------------------------------------------------------------
module plip_rr_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/plip_packet_receive_ring.sv */
// ----------------------------------------------------------------------------
// PLIP packet receive ring
// Receives PLIP frames a byte per beat into a byte ring, commits a frame when
// its additive checksum matches and pops stored packets a byte per read beat.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Direction  Beat
//  --------  -----------------------------------  ---------  -------------------------
//  in        in_valid, in_ready, kind, data       sink       one link event or read
//  out       out_valid, out_ready, rx_status,     source     one result per in beat
//            out_kind, out_byte, out_last,
//            bad_length, packets_waiting
//  cfg       cfg_wr_en, cfg_wr_data               sink       max_len write, no wait
//
// An accepted beat waits in the input register while its result is worked out,
// and the result register loads from it when the beat fires, so one beat per
// cycle is kept while the result register is not stalled. A length-high byte is
// held back while the held length-low byte is written, when the ring was full at
// its length-low byte and room has been freed since. Reset empties the ring at
// once (no clearing pass); a stalled result register holds the input register,
// which in turn drops in_ready.
// ----------------------------------------------------------------------------
module plip_packet_receive_ring #(
	parameter int RING_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data,
	// result beats
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  rx_status,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic        bad_length,
	output logic [11:0] packets_waiting,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	import plip_rr_pkg::*;

	// Pointer, room and packet count widths follow the ring size. Every packet
	// takes at least two bytes, so the count never exceeds half the ring.
	localparam int AW = $clog2(RING_BYTES);
	localparam int FW = $clog2(RING_BYTES + 1);
	localparam int CW = $clog2(RING_BYTES / 2 + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(RING_BYTES - 1);
	localparam logic [FW-1:0] FULL_ROOM = FW'(RING_BYTES);

	// Ring pointers wrap from the last entry back to zero.
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == LAST_ADDR) ? '0 : p + 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [15:0] max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------
	// Input register and handshake
	// ------------------------------------------------------------------
	logic        in_valid_s1;
	kind_t       kind_s1;
	logic [7:0]  data_s1;
	logic        out_valid_q;
	logic        fix_lo;      // holds the beat while a deferred length-low byte is written
	logic        fire;        // the beat in the input register is worked out

	assign fire     = in_valid_s1 && (!out_valid_q || out_ready) && !fix_lo;
	assign in_ready = !in_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind_t'(kind);
			data_s1 <= data;
		end
	end

	// ------------------------------------------------------------------
	// State registers
	// ------------------------------------------------------------------
	rx_phase_t   rx_phase_q, rx_phase_d;
	rd_phase_t   rd_phase_q, rd_phase_d;
	logic [AW-1:0] commit_q, commit_d;
	logic [AW-1:0] tent_q, tent_d;
	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [FW-1:0] free_q, free_d;
	logic [CW-1:0] count_q, count_d;
	logic [15:0] rx_len_q, rx_len_d;
	logic [15:0] rx_rem_q, rx_rem_d;
	logic [7:0]  rx_sum_q, rx_sum_d;
	logic [15:0] rd_len_q, rd_len_d;
	logic [15:0] rd_rem_q, rd_rem_d;
	logic        lo_done_q, lo_done_d;

	// Ring memory interface
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	// ------------------------------------------------------------------
	// Receive side
	// ------------------------------------------------------------------
	logic [15:0] len_full;
	logic        no_room;
	logic        rx_commit;
	rx_status_t  status_c;
	logic        rx_we;
	logic [AW-1:0] rx_waddr;

	assign len_full = {data_s1, rx_len_q[7:0]};
	assign no_room  = (18'(len_full) + 18'd2) > 18'(free_q);

	// The length-low byte is written when it arrives if the ring has any
	// space. Otherwise it is written while the length-high byte is held, once that
	// byte shows that the frame fits after all.
	assign fix_lo = in_valid_s1 && (kind_s1 == KIND_BYTE) && (rx_phase_q == RX_LEN_HI) &&
		!lo_done_q && !no_room;

	// Next receive phase.
	always_comb begin
		rx_phase_d = rx_phase_q;
		case (kind_s1)
			KIND_START: begin
				rx_phase_d = RX_LEN_LO;
			end
			KIND_BYTE: begin
				case (rx_phase_q)
					RX_LEN_LO: rx_phase_d = RX_LEN_HI;
					RX_LEN_HI: begin
						if (no_room) begin
							rx_phase_d = RX_IDLE;
						end else if (len_full == 16'd0) begin
							rx_phase_d = RX_SUM;
						end else begin
							rx_phase_d = RX_DATA;
						end
					end
					RX_DATA: begin
						if (rx_rem_q == 16'd1) begin
							rx_phase_d = RX_SUM;
						end
					end
					RX_SUM:  rx_phase_d = RX_IDLE;
					default: rx_phase_d = rx_phase_q;
				endcase
			end
			KIND_TIMEOUT: begin
				rx_phase_d = RX_IDLE;
			end
			default: rx_phase_d = rx_phase_q;
		endcase
	end

	// Receive datapath and status.
	always_comb begin
		status_c  = ST_NONE;
		rx_we     = 1'b0;
		rx_waddr  = tent_q;
		tent_d    = tent_q;
		commit_d  = commit_q;
		rx_len_d  = rx_len_q;
		rx_rem_d  = rx_rem_q;
		rx_sum_d  = rx_sum_q;
		lo_done_d = lo_done_q;
		rx_commit = 1'b0;
		case (kind_s1)
			KIND_START: begin
				if (rx_phase_q != RX_IDLE) begin
					status_c = ST_ABORTED;
				end
				tent_d    = commit_q;
				rx_len_d  = 16'd0;
				rx_rem_d  = 16'd0;
				rx_sum_d  = 8'd0;
				lo_done_d = 1'b0;
			end
			KIND_BYTE: begin
				case (rx_phase_q)
					RX_LEN_LO: begin
						rx_len_d  = {8'd0, data_s1};
						rx_we     = (free_q != '0);
						lo_done_d = (free_q != '0);
					end
					RX_LEN_HI: begin
						rx_len_d = len_full;
						if (no_room) begin
							status_c = ST_NO_ROOM;
						end else begin
							rx_we    = 1'b1;
							rx_waddr = ptr_inc(tent_q);
							tent_d   = ptr_inc(ptr_inc(tent_q));
							rx_rem_d = len_full;
						end
					end
					RX_DATA: begin
						rx_we    = 1'b1;
						tent_d   = ptr_inc(tent_q);
						rx_sum_d = rx_sum_q + data_s1;
						rx_rem_d = rx_rem_q - 16'd1;
					end
					RX_SUM: begin
						if (data_s1 == rx_sum_q) begin
							commit_d  = tent_q;
							rx_commit = 1'b1;
							status_c  = ST_ACCEPTED;
						end else begin
							status_c = ST_CSUM_ERR;
						end
					end
					default: status_c = ST_NONE;
				endcase
			end
			KIND_TIMEOUT: begin
				if (rx_phase_q != RX_IDLE) begin
					status_c = ST_ABORTED;
				end
			end
			default: status_c = ST_NONE;
		endcase
	end

	always_comb begin
		if (fix_lo) begin
			ram_we    = 1'b1;
			ram_waddr = tent_q;
			ram_wdata = rx_len_q[7:0];
		end else begin
			ram_we    = fire && rx_we;
			ram_waddr = rx_waddr;
			ram_wdata = data_s1;
		end
	end

	// ------------------------------------------------------------------
	// Read side
	// ------------------------------------------------------------------
	logic [15:0] rd_len_full;
	logic [15:0] rd_rem_dec;
	logic        rd_finish;
	logic        rd_pop;
	out_kind_t   okind_c;
	logic        olast_c;
	logic        bad_c;

	assign rd_len_full = {ram_rdata, rd_len_q[7:0]};
	assign rd_rem_dec  = (rd_rem_q != 16'd0) ? rd_rem_q - 16'd1 : 16'd0;

	// Next read phase.
	always_comb begin
		rd_phase_d = rd_phase_q;
		if (kind_s1 == KIND_READ) begin
			case (rd_phase_q)
				RD_START: begin
					if (count_q != '0) begin
						rd_phase_d = RD_LEN_HI;
					end
				end
				RD_LEN_HI: rd_phase_d = (rd_len_full == 16'd0) ? RD_START : RD_DATA;
				RD_DATA: begin
					if (rd_rem_dec == 16'd0) begin
						rd_phase_d = RD_START;
					end
				end
				default: rd_phase_d = RD_START;
			endcase
		end
	end

	// Read datapath and result fields. The ring read data always holds the
	// byte at the read pointer, fetched in the previous cycle.
	always_comb begin
		rd_pop    = 1'b0;
		rd_finish = 1'b0;
		okind_c   = OK_NONE;
		olast_c   = 1'b0;
		bad_c     = 1'b0;
		rd_len_d  = rd_len_q;
		rd_rem_d  = rd_rem_q;
		if (kind_s1 == KIND_READ) begin
			case (rd_phase_q)
				RD_START: begin
					if (count_q != '0) begin
						rd_pop   = 1'b1;
						okind_c  = OK_LEN_LO;
						rd_len_d = {8'd0, ram_rdata};
					end
				end
				RD_LEN_HI: begin
					rd_pop   = 1'b1;
					okind_c  = OK_LEN_HI;
					rd_len_d = rd_len_full;
					bad_c    = (rd_len_full == 16'd0) || (rd_len_full > max_len_q);
					if (rd_len_full == 16'd0) begin
						olast_c   = 1'b1;
						rd_finish = 1'b1;
					end else begin
						rd_rem_d = rd_len_full;
					end
				end
				RD_DATA: begin
					rd_pop   = 1'b1;
					okind_c  = OK_DATA;
					rd_rem_d = rd_rem_dec;
					if (rd_rem_dec == 16'd0) begin
						olast_c   = 1'b1;
						rd_finish = 1'b1;
					end
				end
				default: okind_c = OK_NONE;
			endcase
		end
	end

	assign rd_ptr_d = rd_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;

	// ------------------------------------------------------------------
	// Room and packet count
	// ------------------------------------------------------------------
	logic [17:0] room_freed;

	// A zero-length packet finishes in the length-high phase, where the
	// length register has not been loaded yet; it frees two bytes.
	assign room_freed = 18'(free_q) + 18'(rd_len_d) + 18'd2;

	always_comb begin
		free_d  = free_q;
		count_d = count_q;
		if (rx_commit) begin
			free_d  = FW'(18'(free_q) - (18'(rx_len_q) + 18'd2));
			count_d = count_q + 1'b1;
		end else if (rd_finish) begin
			free_d = (room_freed > 18'(FULL_ROOM)) ? FULL_ROOM : FW'(room_freed);
			if (count_q != '0) begin
				count_d = count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q <= RX_IDLE;
			rd_phase_q <= RD_START;
			commit_q   <= '0;
			tent_q     <= '0;
			rd_ptr_q   <= '0;
			free_q     <= FULL_ROOM;
			count_q    <= '0;
			rx_len_q   <= '0;
			rx_rem_q   <= '0;
			rx_sum_q   <= '0;
			rd_len_q   <= '0;
			rd_rem_q   <= '0;
			lo_done_q  <= 1'b0;
		end else if (fix_lo) begin
			lo_done_q <= 1'b1;
		end else if (fire) begin
			rx_phase_q <= rx_phase_d;
			rd_phase_q <= rd_phase_d;
			commit_q   <= commit_d;
			tent_q     <= tent_d;
			rd_ptr_q   <= rd_ptr_d;
			free_q     <= free_d;
			count_q    <= count_d;
			rx_len_q   <= rx_len_d;
			rx_rem_q   <= rx_rem_d;
			rx_sum_q   <= rx_sum_d;
			rd_len_q   <= rd_len_d;
			rd_rem_q   <= rd_rem_d;
			lo_done_q  <= lo_done_d;
		end
	end

	// Ring memory, read address follows the next read pointer when a beat fires, so the byte
	// to pop is always already registered at the read port.
	plip_rr_ram #(
		.DEPTH (RING_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (fire ? rd_ptr_d : rd_ptr_q),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rx_status       <= status_c;
			out_kind        <= okind_c;
			out_byte        <= rd_pop ? ram_rdata : 8'd0;
			out_last        <= olast_c;
			bad_length      <= bad_c;
			packets_waiting <= 12'(count_d);
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	a_room_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FULL_ROOM)
		else $error("free room above ring size");

	a_reading_has_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_phase_q != RD_START) |-> (count_q != '0))
		else $error("packet read-out in progress with no stored packet");

	a_bad_only_len_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_length) |-> (out_kind == OK_LEN_HI))
		else $error("bad length flag outside the length-high result");

	a_fix_holds_beat: assert property (@(posedge clk) disable iff (!arst_n)
		fix_lo |=> (in_valid_s1 && lo_done_q && $stable(kind_s1) && $stable(data_s1)))
		else $error("deferred length-low write lost its beat");
`endif

endmodule
